/* sv/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge, quiet while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Check a property on every rising edge, reset included.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`else

`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_CLK_ALWAYS(label, clk, prop)

`endif

`endif

/* sv/psif_pkg.sv */
`timescale 1ns / 1ps

package psif_pkg;

  localparam int PdgW      = 31;
  localparam int StatusW   = 9;
  localparam int PtW       = 20;
  localparam int ApbAddrW  = 3;
  localparam int ApbDataW  = 32;

  // Only decimal digits 0..3 are needed; magnitudes under 10^7 fit in 24 bits.
  localparam int BcdDigits = 4;
  localparam int BcdW      = 4 * BcdDigits;
  localparam int BinW      = 24;
  localparam int StepBits  = 8;

  localparam logic [PtW-1:0] PT_MIN_RESET = 20'd32;

  localparam logic [PdgW-1:0] SUSY_LOW     = 31'd1000001;
  localparam logic [PdgW-1:0] SUSY_HIGH    = 31'd1000039;
  localparam logic [PdgW-1:0] BOTTOM_LIMIT = 31'd10000000;
  localparam logic [PdgW-1:0] TAU_CODE     = 31'd15;
  localparam logic [PdgW-1:0] W_CODE       = 31'd24;
  localparam logic [PdgW-1:0] BOSON_TOP    = 31'd43;

  // Register indexes, taken from paddr[2]
  localparam logic REG_PT_MIN     = 1'b0;
  localparam logic REG_REQ_NOT_PU = 1'b1;

  typedef struct packed {
    logic [PtW-1:0] pt_min;
    logic           require_not_pileup;
  } cfg_t;

  typedef logic [BcdW-1:0] bcd_t;

  typedef struct packed {
    logic pass;
    logic exempt;
    logic pt_low;
    logic drop_pu;
    logic bh_range;
  } flags_t;

endpackage

/* sv/psif_apb_regs.sv */
`timescale 1ns / 1ps

module psif_apb_regs
  import psif_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pt_min             <= PT_MIN_RESET;
      cfg.require_not_pileup <= 1'b0;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_PT_MIN:     cfg.pt_min             <= pwdata[PtW-1:0];
        REG_REQ_NOT_PU: cfg.require_not_pileup <= pwdata[0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_PT_MIN:     prdata = {{(ApbDataW-PtW){1'b0}}, cfg.pt_min};
      REG_REQ_NOT_PU: prdata = {{(ApbDataW-1){1'b0}}, cfg.require_not_pileup};
      default:        prdata = '0;
    endcase
  end

endmodule

/* sv/psif_bcd_stage.sv */
`timescale 1ns / 1ps

// Eight shift-and-add-3 steps of a binary to BCD conversion. Low digits never
// depend on higher ones, so only the kept digits are carried.
module psif_bcd_stage
  import psif_pkg::*;
(
  input  bcd_t                bcd_in,
  input  logic [StepBits-1:0] bits,
  output bcd_t                bcd_out
);

  always_comb begin
    bcd_t b;
    b = bcd_in;
    for (int s = 0; s < StepBits; s++) begin
      for (int d = 0; d < BcdDigits; d++) begin
        if (b[4*d +: 4] >= 4'd5) begin
          b[4*d +: 4] = b[4*d +: 4] + 4'd3;
        end
      end
      b = {b[BcdW-2:0], bits[StepBits-1-s]};
    end
    bcd_out = b;
  end

endmodule

/* sv/particle_status_id_filter.sv */
`timescale 1ns / 1ps
// An item goes from its accepting edge to result_valid through the input
// register, magnitude stage, three decimal-digit stages and result register.
// Throughput: one item per cycle; each stage holds only while the stage after
// it is full and stalled. Reset clears all stage valid bits, sets pt_min to 32
// and require_not_pileup to 0.
`include "assert_macros.svh"

module particle_status_id_filter
  import psif_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ApbAddrW-1:0]       paddr,
  input  logic [ApbDataW-1:0]       pwdata,
  output logic [ApbDataW-1:0]       prdata,
  output logic                      pready,
  input  logic                      item_valid,
  output logic                      item_ready,
  input  logic signed [PdgW-1:0]    pdg_code,
  input  logic signed [StatusW-1:0] status,
  input  logic [PtW-1:0]            pt,
  input  logic                      is_pileup,
  input  logic                      has_mother,
  input  logic signed [PdgW-1:0]    mother_pid,
  output logic                      result_valid,
  input  logic                      result_ready,
  output logic                      keep
);

  localparam int NStages = 6;

  cfg_t cfg;

  psif_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  function automatic logic [PdgW-1:0] mag31(input logic [PdgW-1:0] x);
    return x[PdgW-1] ? (~x + PdgW'(1)) : x;
  endfunction

  logic [NStages-1:0] v;
  logic [NStages-1:0] adv;

  // stage 0: raw fields
  logic [PdgW-1:0]           s0_pdg;
  logic signed [StatusW-1:0] s0_st;
  logic [PtW-1:0]            s0_pt;
  logic                      s0_pu;
  logic                      s0_hm;
  logic [PdgW-1:0]           s0_mpid;

  // stage 1: magnitudes
  logic [PdgW-1:0]           s1_m;
  logic [PdgW-1:0]           s1_mm;
  logic signed [StatusW-1:0] s1_st;
  logic [PtW-1:0]            s1_pt;
  logic                      s1_pu;
  logic                      s1_hm;

  // stages 2..4: flags and digits in progress
  flags_t                    s2_fl, s3_fl, s4_fl;
  logic [BinW-StepBits-1:0]  s2_bits;
  logic [StepBits-1:0]       s3_bits;
  bcd_t                      s2_bcd, s3_bcd, s4_bcd;
  bcd_t                      bcd1, bcd2, bcd3;

  flags_t                    fl_next;
  logic                      tau_d, w_d;
  logic                      b_had;
  logic                      keep_next;

  // stage i advances when empty or when stage i+1 advances
  always_comb begin
    adv[NStages-1] = !v[NStages-1] || result_ready;
    for (int i = NStages - 2; i >= 0; i--) begin
      adv[i] = !v[i] || adv[i+1];
    end
  end

  assign item_ready   = adv[0];
  assign result_valid = v[NStages-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) begin
        v[0] <= item_valid;
      end
      for (int i = 1; i < NStages; i++) begin
        if (adv[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // particle classification on magnitudes
  always_comb begin
    w_d   = s1_hm && (s1_mm == W_CODE);
    tau_d = s1_hm && (s1_mm == TAU_CODE) &&
            !((s1_m == TAU_CODE) || (s1_m < 31'd11) ||
              ((s1_m > 31'd22) && (s1_m < 31'd100)) || (s1_m > 31'd1000));
    fl_next.pass = ((s1_m >= SUSY_LOW) && (s1_m <= SUSY_HIGH)) ||
                   (s1_st == 9'sd3) ||
                   ((s1_st > 9'sd20) && (s1_st < 9'sd30)) ||
                   ((s1_m > 31'd10) && (s1_m < 31'd17)) ||
                   ((s1_m >= 31'd4) && (s1_m <= 31'd6)) ||
                   ((s1_m > 31'd22) && (s1_m < BOSON_TOP)) ||
                   ((s1_m == 31'd22) && (s1_st == 9'sd1)) ||
                   tau_d || w_d;
    fl_next.exempt   = (s1_m == 31'd5) || tau_d || w_d;
    fl_next.pt_low   = s1_pt < cfg.pt_min;
    fl_next.drop_pu  = cfg.require_not_pileup && s1_pu;
    fl_next.bh_range = (s1_m < BOTTOM_LIMIT) && (s1_m > 31'd100);
  end

  psif_bcd_stage u_bcd1 (
    .bcd_in  ('0),
    .bits    (s1_m[BinW-1 -: StepBits]),
    .bcd_out (bcd1)
  );

  psif_bcd_stage u_bcd2 (
    .bcd_in  (s2_bcd),
    .bits    (s2_bits[BinW-StepBits-1 -: StepBits]),
    .bcd_out (bcd2)
  );

  psif_bcd_stage u_bcd3 (
    .bcd_in  (s3_bcd),
    .bits    (s3_bits),
    .bcd_out (bcd3)
  );

  // bottom hadron: a digit of 5 among digits 1..3, fundamental codes excluded
  always_comb begin
    logic [3:0] d0, d1, d2, d3;
    logic       fundamental;
    d0 = s4_bcd[3:0];
    d1 = s4_bcd[7:4];
    d2 = s4_bcd[11:8];
    d3 = s4_bcd[15:12];
    fundamental = (d2 == 4'd0) && (d3 == 4'd0) && ((d1 != 4'd0) || (d0 != 4'd0));
    b_had = s4_fl.bh_range && !fundamental &&
            ((d1 == 4'd5) || (d2 == 4'd5) || (d3 == 4'd5));
    keep_next = (s4_fl.pass || b_had) &&
                !(s4_fl.pt_low && !(s4_fl.exempt || b_had)) &&
                !s4_fl.drop_pu;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s0_pdg  <= pdg_code;
      s0_st   <= status;
      s0_pt   <= pt;
      s0_pu   <= is_pileup;
      s0_hm   <= has_mother;
      s0_mpid <= mother_pid;
    end
    if (adv[1]) begin
      s1_m  <= mag31(s0_pdg);
      s1_mm <= mag31(s0_mpid);
      s1_st <= s0_st;
      s1_pt <= s0_pt;
      s1_pu <= s0_pu;
      s1_hm <= s0_hm;
    end
    if (adv[2]) begin
      s2_fl   <= fl_next;
      s2_bcd  <= bcd1;
      s2_bits <= s1_m[BinW-StepBits-1:0];
    end
    if (adv[3]) begin
      s3_fl   <= s2_fl;
      s3_bcd  <= bcd2;
      s3_bits <= s2_bits[StepBits-1:0];
    end
    if (adv[4]) begin
      s4_fl  <= s3_fl;
      s4_bcd <= bcd3;
    end
    if (adv[5]) begin
      keep <= keep_next;
    end
  end

  `ASSERT_CLK(a_ready_when_empty, clk, rst, (v == '0) |-> item_ready)
  `ASSERT_CLK(a_result_from_last_stage, clk, rst,
              $rose(result_valid) |-> $past(v[NStages-2]))
  `ASSERT_CLK(a_last_stage_moves, clk, rst,
              (v[NStages-2] && adv[NStages-1]) |=> result_valid)
  `ASSERT_CLK(a_digits_decimal, clk, rst,
              v[4] |-> ((s4_bcd[3:0] <= 4'd9) && (s4_bcd[7:4] <= 4'd9) &&
                        (s4_bcd[11:8] <= 4'd9) && (s4_bcd[15:12] <= 4'd9)))
  `ASSERT_CLK_ALWAYS(a_apb_ready, clk, pready)

endmodule
